>>> sv/periodic_release_scheduler_unit_assert.svh
// Assertion macros for the checker file of the release scheduler.
`ifndef PERIODIC_RELEASE_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_RELEASE_SCHEDULER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define PRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that is checked during reset as well.
`define PRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/prs_pkg.sv
// Package with the types and constants of the periodic release scheduler.
`default_nettype none
package prs_pkg;

  localparam int unsigned TIME_W = 63;
  localparam int unsigned CNT_W  = $clog2(TIME_W);
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_NOCFG = 2'd2
  } prs_status_e;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_FIRST  = 2'd1,
    REG_PERIOD = 2'd2,
    REG_POLICY = 2'd3
  } prs_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_DIV,
    S_PREP,
    S_SUM,
    S_EMIT
  } prs_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } prs_div_stat_t;

  typedef struct packed {
    prs_status_e       status;
    logic [TIME_W-1:0] sched;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] late;
    logic [TIME_W-1:0] missed;
    logic [TIME_W-1:0] nxt;
  } prs_res_t;

endpackage
`default_nettype wire

>>> sv/prs_if.sv
// Handshake interfaces for the tick input and the release result channels.
`default_nettype none
interface prs_tick_if;
  logic                       valid;
  logic                       ready;
  logic [prs_pkg::TIME_W-1:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink (input valid, input now_time, output ready);
  modport monitor (input valid, input now_time, input ready);
endinterface

interface prs_rel_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [prs_pkg::TIME_W-1:0] sched_ns;
  logic [prs_pkg::TIME_W-1:0] wake_ns;
  logic [prs_pkg::TIME_W-1:0] lateness;
  logic [prs_pkg::TIME_W-1:0] missed_count;
  logic [prs_pkg::TIME_W-1:0] next_release_out;

  modport source (output valid, output status, output sched_ns, output wake_ns,
                  output lateness, output missed_count, output next_release_out,
                  input ready);
  modport sink (input valid, input status, input sched_ns, input wake_ns,
                input lateness, input missed_count, input next_release_out,
                output ready);
  modport monitor (input valid, input status, input sched_ns, input wake_ns,
                   input lateness, input missed_count, input next_release_out,
                   input ready);
endinterface
`default_nettype wire

>>> sv/periodic_release_scheduler_unit.sv
// Top level of the periodic release scheduler with its sequencer and registers.
//
// Usage: each item on the tick channel carries the current time in nanoseconds.
// A tick earlier than the next release produces no result. Otherwise one item
// leaves on the release channel with the served release, the wake time, the
// lateness, the whole periods missed and the next release. A disabled block
// answers every tick with a not-configured status; a zero period or a next
// release beyond the 63-bit range answers with an overflow status.
// The user must write configuration through the write port only while the block
// is idle; the block itself does not enforce this. After the accept the
// sequencer compares the tick with the next release and starts the restoring
// divider, which yields one quotient bit per cycle and then flags completion;
// the sequencer then prepares the addends, adds them with an overflow check and
// registers the result, which waits in the emit state while the receiver stalls
// the previous one. An early tick returns to idle from the compare; a disabled
// block goes from idle straight to the emit state and a zero period from the
// compare. The tick channel is ready only while the sequencer is idle.
// Reset clears the sequencer, the schedule and the result valid flag and loads
// the register defaults. A stalled receiver holds the registered result; the
// block takes the next tick meanwhile and waits only to hand over the next one.
`default_nettype none
module periodic_release_scheduler_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [prs_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [prs_pkg::TIME_W-1:0] cfg_data_i,
  prs_tick_if.sink                        tick_i,
  prs_rel_if.source                       rel_o
);
  import prs_pkg::*;

  prs_state_e        state_q, state_d;
  logic              en_q, en_d;
  logic              pol_q, pol_d;
  logic              armed_q, armed_d;
  logic [TIME_W-1:0] first_q, first_d;
  logic [TIME_W-1:0] per_q, per_d;
  logic [TIME_W-1:0] nrt_q, nrt_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] base_q, base_d;
  logic [TIME_W-1:0] add_q, add_d;
  prs_res_t          res_q, res_d;
  prs_res_t          out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              div_start;
  prs_div_stat_t     div_stat;
  logic [TIME_W-1:0] div_quot;
  logic [TIME_W-1:0] div_rem;
  logic [TIME_W-1:0] ela;
  logic [TIME_W:0]   sum;

  assign ela = now_q - nrt_q;
  assign sum = {1'b0, base_q} + {1'b0, add_q};

  prs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ela),
    .divisor_i  (per_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign tick_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    en_d      = en_q;
    pol_d     = pol_q;
    armed_d   = armed_q;
    first_d   = first_q;
    per_d     = per_q;
    nrt_d     = nrt_q;
    now_d     = now_q;
    base_d    = base_q;
    add_d     = add_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rel_o.ready;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (tick_i.valid) begin
          now_d = tick_i.now_time;
          if (!en_q) begin
            armed_d = 1'b0;
            res_d   = '0;
            res_d.status = ST_NOCFG;
            state_d = S_EMIT;
          end else begin
            if (!armed_q) begin
              nrt_d   = first_q;
              armed_d = 1'b1;
            end
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (now_q < nrt_q) begin
          state_d = S_IDLE;
        end else if (per_q == '0) begin
          res_d        = '0;
          res_d.status = ST_OVF;
          state_d      = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (pol_q) begin
          base_d = now_q;
          add_d  = per_q - div_rem;
        end else begin
          base_d = nrt_q;
          add_d  = per_q;
        end
        state_d = S_SUM;
      end
      S_SUM: begin
        res_d = '0;
        if (sum[TIME_W]) begin
          res_d.status = ST_OVF;
        end else begin
          res_d.status = ST_OK;
          res_d.sched  = nrt_q;
          res_d.wake   = now_q;
          res_d.late   = now_q - nrt_q;
          res_d.missed = div_quot;
          res_d.nxt    = sum[TIME_W-1:0];
          nrt_d        = sum[TIME_W-1:0];
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_q || rel_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE: begin
          en_d    = cfg_data_i[0];
          armed_d = 1'b0;
        end
        REG_FIRST:  first_d = cfg_data_i;
        REG_PERIOD: per_d = cfg_data_i;
        REG_POLICY: pol_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      en_q      <= 1'b0;
      pol_q     <= 1'b0;
      armed_q   <= 1'b0;
      first_q   <= '0;
      per_q     <= TIME_W'(1);
      nrt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      en_q      <= en_d;
      pol_q     <= pol_d;
      armed_q   <= armed_d;
      first_q   <= first_d;
      per_q     <= per_d;
      nrt_q     <= nrt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    base_q <= base_d;
    add_q  <= add_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign rel_o.valid            = out_vld_q;
  assign rel_o.status           = out_q.status;
  assign rel_o.sched_ns         = out_q.sched;
  assign rel_o.wake_ns          = out_q.wake;
  assign rel_o.lateness         = out_q.late;
  assign rel_o.missed_count     = out_q.missed;
  assign rel_o.next_release_out = out_q.nxt;

endmodule
`default_nettype wire

>>> sv/prs_div.sv
// Radix-2 restoring divider that yields one quotient bit per cycle.
`default_nettype none
module prs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [prs_pkg::TIME_W-1:0] dividend_i,
  input  wire logic [prs_pkg::TIME_W-1:0] divisor_i,
  output prs_pkg::prs_div_stat_t          stat_o,
  output logic [prs_pkg::TIME_W-1:0]      quot_o,
  output logic [prs_pkg::TIME_W-1:0]      rem_o
);
  import prs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] acc_q, acc_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dsr_q, dsr_d;
  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] diff;

  assign shifted = {rem_q, acc_q[TIME_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(TIME_W - 1);
      acc_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[TIME_W+1]) begin
        rem_d = shifted[TIME_W-1:0];
        acc_d = {acc_q[TIME_W-2:0], 1'b0};
      end else begin
        rem_d = diff[TIME_W-1:0];
        acc_d = {acc_q[TIME_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;
  assign rem_o       = rem_q;

endmodule
`default_nettype wire

>>> sv/prs_checker.sv
// Port-level checker of the periodic release scheduler and its bind statement.
`include "periodic_release_scheduler_unit_assert.svh"
`default_nettype none
module prs_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       tick_valid_i,
  input  wire logic                       tick_ready_i,
  input  wire logic                       rel_valid_i,
  input  wire logic                       rel_ready_i,
  input  wire logic [1:0]                 rel_status_i,
  input  wire logic [prs_pkg::TIME_W-1:0] rel_sched_i,
  input  wire logic [prs_pkg::TIME_W-1:0] rel_wake_i,
  input  wire logic [prs_pkg::TIME_W-1:0] rel_late_i,
  input  wire logic [prs_pkg::TIME_W-1:0] rel_missed_i,
  input  wire logic [prs_pkg::TIME_W-1:0] rel_nxt_i
);
  import prs_pkg::*;

  `PRS_ASSERT(a_rel_hold, rel_valid_i && !rel_ready_i |=> rel_valid_i &&
    $stable(rel_status_i) && $stable(rel_nxt_i), "Stalled result item changed.")
  `PRS_ASSERT(a_busy_after_tick, tick_valid_i && tick_ready_i |=> !tick_ready_i,
    "Tick channel stayed ready after an accepted item.")
  `PRS_ASSERT(a_err_zero, rel_valid_i && rel_status_i != ST_OK |-> rel_sched_i == '0 &&
    rel_wake_i == '0 && rel_late_i == '0 && rel_missed_i == '0 && rel_nxt_i == '0,
    "Error result item carries nonzero fields.")
  `PRS_ASSERT(a_ok_order, rel_valid_i && rel_status_i == ST_OK |-> rel_wake_i >= rel_sched_i &&
    rel_nxt_i > rel_sched_i && rel_late_i == rel_wake_i - rel_sched_i,
    "Result item times are inconsistent.")
  `PRS_ASSERT_RST(a_rst_quiet, !rst_ni |-> !rel_valid_i, "Result item offered during reset.")

endmodule

bind periodic_release_scheduler_unit prs_checker u_prs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tick_valid_i (tick_i.valid),
  .tick_ready_i (tick_i.ready),
  .rel_valid_i  (rel_o.valid),
  .rel_ready_i  (rel_o.ready),
  .rel_status_i (rel_o.status),
  .rel_sched_i  (rel_o.sched_ns),
  .rel_wake_i   (rel_o.wake_ns),
  .rel_late_i   (rel_o.lateness),
  .rel_missed_i (rel_o.missed_count),
  .rel_nxt_i    (rel_o.next_release_out)
);
`default_nettype wire
